// File: sv/ils_pkg.sv
package ils_pkg;

   // Number of cells in the chain, one stored word per cell.
   localparam int CAPACITY = 64;

   localparam int WORD_W  = 32;
   localparam int KIND_W  = 3;
   localparam int POS_W   = 7;
   localparam int STAT_W  = 2;
   localparam int OUT_CNT_W = 7;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Read gather tree: cells are OR-ed in groups, then the groups are OR-ed.
   localparam int GROUP_SIZE = 8;
   localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

   typedef enum logic [KIND_W-1:0] {
      REQ_READ   = 3'd0,
      REQ_HEAD   = 3'd1,
      REQ_TAIL   = 3'd2,
      REQ_AT     = 3'd3,
      REQ_DELETE = 3'd4
   } req_kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_DELETE = 2'd2
   } cell_op_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      cell_op_type        op;
      logic               rd_en;
      logic [CMP_W-1:0]   pos;
      logic [WORD_W-1:0]  word;
   } cell_cmd_type;

endpackage

// File: sv/ils_cell.sv
module ils_cell (
   input  logic                          clock,
   input  logic [ils_pkg::IDX_W-1:0]     cell_index,
   input  ils_pkg::cell_cmd_type         cmd,
   input  logic [ils_pkg::WORD_W-1:0]    left_word,
   input  logic [ils_pkg::WORD_W-1:0]    right_word,
   output logic [ils_pkg::WORD_W-1:0]    word_out,
   output logic [ils_pkg::WORD_W-1:0]    read_out
);

   logic [ils_pkg::WORD_W-1:0] word_ff;
   logic [ils_pkg::WORD_W-1:0] word_in;
   logic [ils_pkg::CMP_W-1:0]  idx_ext;

   assign idx_ext = ils_pkg::CMP_W'(cell_index);

   // An insert pulls from the left neighbour above the slot; a delete pulls
   // from the right neighbour at and above the slot.
   always_comb begin
      word_in = word_ff;
      unique case (cmd.op)
         ils_pkg::CELL_INSERT: begin
            if (idx_ext > cmd.pos) begin
               word_in = left_word;
            end else if (idx_ext == cmd.pos) begin
               word_in = cmd.word;
            end
         end
         ils_pkg::CELL_DELETE: begin
            if (idx_ext >= cmd.pos) begin
               word_in = right_word;
            end
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;
   assign read_out = (cmd.rd_en && (idx_ext == cmd.pos)) ? word_ff : '0;

endmodule

// File: sv/ils_gather.sv
module ils_gather (
   input  logic                          clock,
   input  logic [ils_pkg::WORD_W-1:0]    cell_read [ils_pkg::CAPACITY],
   output logic [ils_pkg::WORD_W-1:0]    read_word
);

   logic [ils_pkg::WORD_W-1:0] group_ff [ils_pkg::NUM_GROUPS];
   logic [ils_pkg::WORD_W-1:0] group_in [ils_pkg::NUM_GROUPS];
   logic [ils_pkg::WORD_W-1:0] total_ff;
   logic [ils_pkg::WORD_W-1:0] total_in;

   // At most one cell drives a non-zero word, so an OR tree selects it.
   always_comb begin
      for (int g = 0; g < ils_pkg::NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < ils_pkg::GROUP_SIZE; k++) begin
            if (g * ils_pkg::GROUP_SIZE + k < ils_pkg::CAPACITY) begin
               group_in[g] = group_in[g] | cell_read[g * ils_pkg::GROUP_SIZE + k];
            end
         end
      end
   end

   always_comb begin
      total_in = '0;
      for (int g = 0; g < ils_pkg::NUM_GROUPS; g++) begin
         total_in = total_in | group_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
      total_ff <= total_in;
   end

   assign read_word = total_ff;

endmodule

// File: sv/indexed_list_store.sv
// Channel   Direction  Handshake                  Payload
// request   in         start high, busy low       req_type, req_position, req_word_in
// result    out        rsp_valid, one-cycle pulse rsp_read_word, rsp_found, rsp_status,
//                                                 rsp_entry_count
//
// At the edge that accepts a request the cell chain shifts, the count updates and
// the first level of the registered OR tree (group_ff) takes the read word; the
// second level (total_ff) takes it after that, the result strobes once it holds,
// and the next request may enter at the edge that ends the strobe.
// A new request is held off while the previous one is between the two levels of the gather tree.
// Reset clears the count and the control flags; the cell words are left as they are.
// The receiver cannot stall, so busy depends on the gather tree alone.
module indexed_list_store (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [ils_pkg::KIND_W-1:0]        req_type,
   input  logic [ils_pkg::POS_W-1:0]         req_position,
   input  logic signed [ils_pkg::WORD_W-1:0] req_word_in,
   output logic                              rsp_valid,
   output logic signed [ils_pkg::WORD_W-1:0] rsp_read_word,
   output logic                              rsp_found,
   output logic [ils_pkg::STAT_W-1:0]        rsp_status,
   output logic [ils_pkg::OUT_CNT_W-1:0]     rsp_entry_count
);

   // Control state.
   logic                        stage1_valid_ff;
   logic                        rsp_valid_ff;
   logic [ils_pkg::CNT_W-1:0]   count_ff;
   logic [ils_pkg::CNT_W-1:0]   count_in;

   // Result fields held from the accepting edge until the next request.
   ils_pkg::status_type         status_ff;
   ils_pkg::status_type         status_in;
   logic                        found_ff;
   logic                        found_in;

   logic                        accept;
   logic [ils_pkg::CMP_W-1:0]   pos_ext;
   logic [ils_pkg::CMP_W-1:0]   cnt_ext;
   logic                        full;
   ils_pkg::cell_cmd_type       cmd;

   logic [ils_pkg::WORD_W-1:0]  cell_word [ils_pkg::CAPACITY];
   logic [ils_pkg::WORD_W-1:0]  cell_read [ils_pkg::CAPACITY];
   logic [ils_pkg::WORD_W-1:0]  gathered;

   assign accept  = start && !stage1_valid_ff;
   assign pos_ext = ils_pkg::CMP_W'(req_position);
   assign cnt_ext = ils_pkg::CMP_W'(count_ff);
   assign full    = (cnt_ext >= ils_pkg::CMP_W'(ils_pkg::CAPACITY));

   // Decode the request into one command for the whole chain, together with
   // the status and the new count. The position error of an insert at a
   // position is checked before the full condition.
   always_comb begin
      cmd.op    = ils_pkg::CELL_HOLD;
      cmd.rd_en = 1'b0;
      cmd.pos   = pos_ext;
      cmd.word  = req_word_in;
      status_in = ils_pkg::ST_DONE;
      found_in  = 1'b0;
      count_in  = count_ff;
      unique case (req_type)
         ils_pkg::REQ_READ: begin
            if (pos_ext < cnt_ext) begin
               cmd.rd_en = 1'b1;
               found_in  = 1'b1;
            end else begin
               status_in = ils_pkg::ST_RANGE;
            end
         end
         ils_pkg::REQ_HEAD, ils_pkg::REQ_TAIL: begin
            if (full) begin
               status_in = ils_pkg::ST_FULL;
            end else begin
               cmd.op   = ils_pkg::CELL_INSERT;
               cmd.pos  = (req_type == ils_pkg::REQ_HEAD) ? '0 : cnt_ext;
               count_in = count_ff + 1'b1;
            end
         end
         ils_pkg::REQ_AT: begin
            if (pos_ext > cnt_ext) begin
               status_in = ils_pkg::ST_RANGE;
            end else if (full) begin
               status_in = ils_pkg::ST_FULL;
            end else begin
               cmd.op   = ils_pkg::CELL_INSERT;
               count_in = count_ff + 1'b1;
            end
         end
         ils_pkg::REQ_DELETE: begin
            if (pos_ext < cnt_ext) begin
               cmd.op   = ils_pkg::CELL_DELETE;
               count_in = count_ff - 1'b1;
            end else begin
               status_in = ils_pkg::ST_RANGE;
            end
         end
         default: begin
            status_in = ils_pkg::ST_DONE;
         end
      endcase
      // Nothing reaches the cells unless the request is taken this cycle.
      if (!accept) begin
         cmd.op    = ils_pkg::CELL_HOLD;
         cmd.rd_en = 1'b0;
      end
   end

   // The chain of storage cells; each one sees its two neighbours.
   for (genvar i = 0; i < ils_pkg::CAPACITY; i++) begin : g_cell
      logic [ils_pkg::WORD_W-1:0] left_w;
      logic [ils_pkg::WORD_W-1:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_inner_l
         assign left_w = cell_word[i-1];
      end

      if (i == ils_pkg::CAPACITY - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_inner_r
         assign right_w = cell_word[i+1];
      end

      ils_cell u_cell (
         .clock      (clock),
         .cell_index (ils_pkg::IDX_W'(i)),
         .cmd        (cmd),
         .left_word  (left_w),
         .right_word (right_w),
         .word_out   (cell_word[i]),
         .read_out   (cell_read[i])
      );
   end

   ils_gather u_gather (
      .clock     (clock),
      .cell_read (cell_read),
      .read_word (gathered)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_valid_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         count_ff        <= '0;
      end else begin
         stage1_valid_ff <= accept;
         rsp_valid_ff    <= stage1_valid_ff;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         found_ff  <= found_in;
      end
   end

   assign busy            = stage1_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_word   = gathered;
   assign rsp_found       = found_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = ils_pkg::OUT_CNT_W'(count_ff);

   // The gather stage and the result strobe never overlap.
   a_stage_excl: assert property (@(posedge clock) disable iff (reset)
      !(stage1_valid_ff && rsp_valid_ff))
      else $error("gather stage and result strobe overlap");

   // A result strobe always follows a gather cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(stage1_valid_ff))
      else $error("result strobe without a preceding request");

   // The count stays within the chain length.
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ils_pkg::CNT_W'(ils_pkg::CAPACITY))
      else $error("entry count beyond capacity");

   // The count moves only when a request is taken.
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("entry count changed without a request");

   // A hit is only ever reported with a clean status.
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && found_ff) |-> (status_ff == ils_pkg::ST_DONE))
      else $error("hit reported with an error status");

endmodule
